FILE: hdl/jitrl_pkg.sv
// Shared types, codes and constants of the joint impedance torque rate limiter.
package jitrl_pkg;

   localparam int JOINTS = 7;
   localparam int JW = 3;

   localparam logic [1:0] KIND_LOAD    = 2'd0;
   localparam logic [1:0] KIND_START   = 2'd1;
   localparam logic [1:0] KIND_CONTROL = 2'd2;
   localparam logic [1:0] KIND_UNUSED  = 2'd3;

   localparam logic [1:0] CSR_CORIOLIS = 2'd0;
   localparam logic [1:0] CSR_MAXSTEP  = 2'd1;
   localparam logic [1:0] CSR_WEIGHT   = 2'd2;

   localparam logic signed [31:0] CORIOLIS_RESET = 32'sd65536;
   localparam logic [30:0] MAXSTEP_RESET = 31'd65536;
   localparam logic [16:0] WEIGHT_RESET  = 17'd64881;

   // One classified item as it travels from the front to the back.
   typedef struct packed {
      logic [1:0]         kind;
      logic [JW-1:0]      joint;
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic signed [31:0] coriolis_torque;
      logic signed [31:0] velocity_command;
      logic signed [31:0] previous_torque;
      logic [23:0]        time_step;
      logic [30:0]        stiffness;
      logic [30:0]        damping;
   } item_type;

   typedef struct packed {
      logic signed [31:0] coriolis_scale;
      logic [30:0]        max_torque_step;
      logic [16:0]        filter_weight;
   } cfg_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      if (x > 66'sd2147483647) return 32'sh7fffffff;
      if (x < -66'sd2147483648) return 32'sh80000000;
      return x[31:0];
   endfunction

endpackage

FILE: hdl/jitrl_front.sv
// Front part: accepts items, drops ignored ones, and queues the rest.
module jitrl_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  jitrl_pkg::item_type    in_item,
   output logic                   q_valid,
   input  logic                   q_ready,
   output jitrl_pkg::item_type    q_item
);
   jitrl_pkg::item_type mem_ff [4];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic keep, push, pop;

   assign in_ready = (cnt_ff != 3'd4);
   assign keep = (in_item.joint < 3'(jitrl_pkg::JOINTS)) &&
                 (in_item.kind != jitrl_pkg::KIND_UNUSED);
   assign push = in_valid && in_ready && keep;
   assign pop  = q_valid && q_ready;
   assign q_valid = (cnt_ff != 3'd0);
   assign q_item = mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 2'd1 : wr_ff;
      rd_in = pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff + {2'd0, push} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= in_item;
      end
   end
endmodule

FILE: hdl/jitrl_back.sv
// Back part: a sequencer that runs one queued item through a shared multiplier.
module jitrl_back (
   input  logic                   clock,
   input  logic                   reset,
   input  jitrl_pkg::cfg_type     cfg,
   input  logic                   q_valid,
   output logic                   q_ready,
   input  jitrl_pkg::item_type    q_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_joint_out,
   output logic signed [31:0]     rsp_torque_command,
   output logic                   rsp_clipped
);
   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001, S_FILT_A = 11'b00000000010, S_FILT_B = 11'b00000000100,
      S_POS   = 11'b00000001000, S_COR    = 11'b00000010000, S_STIF   = 11'b00000100000,
      S_DAMP  = 11'b00001000000, S_LIMIT  = 11'b00010000000, S_OUT    = 11'b00100000000,
      S_SAT   = 11'b01000000000, S_SUM    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   jitrl_pkg::item_type it_ff;
   logic signed [31:0] dpos_ff [jitrl_pkg::JOINTS];
   logic signed [31:0] fvel_ff [jitrl_pkg::JOINTS];
   logic [30:0] kp_ff [jitrl_pkg::JOINTS];
   logic [30:0] kd_ff [jitrl_pkg::JOINTS];
   logic signed [65:0] acc_ff;
   logic signed [65:0] prod_ff;
   logic signed [49:0] tau_ff;
   logic signed [33:0] ma, mb;
   logic signed [67:0] mp;
   logic [16:0] w;
   logic signed [31:0] fv, dp;
   logic signed [50:0] diff, lim, step;
   logic signed [50:0] cmd;
   logic busy_out;

   assign w = (cfg.filter_weight > 17'd65536) ? 17'd65536 : cfg.filter_weight;
   assign fv = fvel_ff[it_ff.joint];
   assign dp = dpos_ff[it_ff.joint];
   assign q_ready = (state_ff == S_IDLE);
   assign busy_out = (state_ff == S_OUT);
   assign rsp_valid = busy_out;

   // Operand select for the single 34x34 multiplier.
   always_comb begin
      ma = '0;
      mb = '0;
      unique case (state_ff)
         S_FILT_A: begin
            ma = $signed({17'd0, 17'd65536 - w});
            mb = 34'(fv);
         end
         S_FILT_B: begin
            ma = $signed({17'd0, w});
            mb = 34'(it_ff.velocity);
         end
         S_POS: begin
            ma = 34'(it_ff.velocity_command);
            mb = $signed({10'd0, it_ff.time_step});
         end
         S_COR: begin
            ma = 34'(cfg.coriolis_scale);
            mb = 34'(it_ff.coriolis_torque);
         end
         S_STIF: begin
            ma = $signed({3'd0, kp_ff[it_ff.joint]});
            mb = 34'(dp) - 34'(it_ff.position);
         end
         S_DAMP: begin
            ma = $signed({3'd0, kd_ff[it_ff.joint]});
            mb = 34'(it_ff.velocity_command) - 34'(fv);
         end
         default: ;
      endcase
      mp = ma * mb;
   end

   always_comb begin
      step = $signed({20'd0, cfg.max_torque_step});
      diff = 51'(tau_ff) - 51'(it_ff.previous_torque);
      lim = diff;
      if (diff > step) lim = step;
      if (diff < -step) lim = -step;
      cmd = 51'(it_ff.previous_torque) + lim;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:
            if (q_valid)
               state_in = (q_item.kind == jitrl_pkg::KIND_CONTROL) ? S_FILT_A : S_IDLE;
         S_FILT_A: state_in = S_FILT_B;
         S_FILT_B: state_in = S_SAT;
         S_SAT: state_in = S_POS;
         S_POS: state_in = S_COR;
         S_COR: state_in = S_STIF;
         S_STIF: state_in = S_DAMP;
         S_DAMP: state_in = S_SUM;
         S_SUM: state_in = S_LIMIT;
         S_LIMIT: state_in = S_OUT;
         S_OUT: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < jitrl_pkg::JOINTS; i++) begin
            dpos_ff[i] <= '0;
            fvel_ff[i] <= '0;
            kp_ff[i] <= '0;
            kd_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == S_IDLE && q_valid) begin
            if (q_item.kind == jitrl_pkg::KIND_LOAD) begin
               kp_ff[q_item.joint] <= q_item.stiffness;
               kd_ff[q_item.joint] <= q_item.damping;
            end
            if (q_item.kind == jitrl_pkg::KIND_START) dpos_ff[q_item.joint] <= q_item.position;
         end
         if (state_ff == S_SAT)
            fvel_ff[it_ff.joint] <= jitrl_pkg::sat32((acc_ff + 66'sd32768) >>> 16);
         if (state_ff == S_COR)
            dpos_ff[it_ff.joint] <= jitrl_pkg::sat32(66'(dp) + ((prod_ff + 66'sd8388608) >>> 24));
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && q_valid) it_ff <= q_item;
      prod_ff <= $signed(mp[65:0]);
      // The old-sample product sits in prod_ff while the new-sample product is formed.
      if (state_ff == S_FILT_B) acc_ff <= prod_ff + $signed(mp[65:0]);
      if (state_ff == S_STIF || state_ff == S_DAMP || state_ff == S_SUM)
         tau_ff <= ((state_ff == S_STIF) ? 50'sd0 : tau_ff) + 50'((prod_ff + 66'sd32768) >>> 16);
      if (state_ff == S_LIMIT) begin
         rsp_joint_out <= it_ff.joint;
         rsp_torque_command <= jitrl_pkg::sat32(66'(cmd));
         rsp_clipped <= (66'(jitrl_pkg::sat32(66'(cmd))) != 66'(tau_ff));
      end
   end
endmodule

FILE: hdl/joint_impedance_torque_rate_limit_unit.sv
// Top level of the joint impedance controller with torque rate limit.
// Each beat on req_ addresses one joint: load beats store gains, start beats
// latch the desired position, and control beats produce one rsp_ beat with
// the rate-limited torque, joint and clip flag. Load and start beats are
// handled in the back sequencer's idle state; a control beat steps through
// its states in turn, as the single shared 34x34 multiplier forms the six
// products one after another, plus the states that finish the filter, the
// torque sum and the limit. A result held by a low rsp_ready stalls the
// sequencer for as long as it waits. A four-entry queue lets req_ beats be
// taken while the sequencer works or a result waits. Beats with joint 7 or
// kind 3 are dropped.
module joint_impedance_torque_rate_limit_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [2:0]         req_joint,
   input  logic signed [31:0] req_position,
   input  logic signed [31:0] req_velocity,
   input  logic signed [31:0] req_coriolis_torque,
   input  logic signed [31:0] req_velocity_command,
   input  logic signed [31:0] req_previous_torque,
   input  logic [23:0]        req_time_step,
   input  logic [30:0]        req_stiffness,
   input  logic [30:0]        req_damping,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_joint_out,
   output logic signed [31:0] rsp_torque_command,
   output logic               rsp_clipped,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   jitrl_pkg::item_type req_item, q_item;
   jitrl_pkg::cfg_type cfg_ff;
   logic q_valid, q_ready;
   logic [1:0] reg_idx;

   assign req_item = '{kind: req_kind, joint: req_joint, position: req_position,
                       velocity: req_velocity, coriolis_torque: req_coriolis_torque,
                       velocity_command: req_velocity_command,
                       previous_torque: req_previous_torque, time_step: req_time_step,
                       stiffness: req_stiffness, damping: req_damping};

   // Register i lives at byte address 4*i.
   assign pready = 1'b1;
   assign reg_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coriolis_scale <= jitrl_pkg::CORIOLIS_RESET;
         cfg_ff.max_torque_step <= jitrl_pkg::MAXSTEP_RESET;
         cfg_ff.filter_weight <= jitrl_pkg::WEIGHT_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (reg_idx)
            jitrl_pkg::CSR_CORIOLIS: cfg_ff.coriolis_scale <= pwdata;
            jitrl_pkg::CSR_MAXSTEP:  cfg_ff.max_torque_step <= pwdata[30:0];
            jitrl_pkg::CSR_WEIGHT:   cfg_ff.filter_weight <= pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         jitrl_pkg::CSR_CORIOLIS: prdata = cfg_ff.coriolis_scale;
         jitrl_pkg::CSR_MAXSTEP:  prdata = {1'b0, cfg_ff.max_torque_step};
         jitrl_pkg::CSR_WEIGHT:   prdata = {15'd0, cfg_ff.filter_weight};
         default:                 prdata = '0;
      endcase
   end

   jitrl_front u_front (.clock, .reset, .in_valid(req_valid), .in_ready(req_ready),
      .in_item(req_item), .q_valid, .q_ready, .q_item);

   jitrl_back u_back (.clock, .reset, .cfg(cfg_ff), .q_valid, .q_ready, .q_item,
      .rsp_valid, .rsp_ready, .rsp_joint_out, .rsp_torque_command, .rsp_clipped);

   // A result never names a joint outside the arm.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_joint_out < 3'd7) else $error("bad joint on result");

   // The sequencer takes from the queue only while no result is pending.
   assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_ready) |-> !rsp_valid) else $error("queue pop during result");

   // A stalled result keeps its clip flag until the beat is taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_clipped)) else $error("clip flag moved");
endmodule

FILE: dv/joint_impedance_torque_rate_limit_unit_tb.sv
// Self-checking testbench of the joint impedance torque rate limiter.
module joint_impedance_torque_rate_limit_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // One request beat plus, for directed rows, a result typed in by hand.
   typedef struct {
      logic [1:0]         kind;
      logic [2:0]         joint;
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic signed [31:0] coriolis_torque;
      logic signed [31:0] velocity_command;
      logic signed [31:0] previous_torque;
      logic [23:0]        time_step;
      logic [30:0]        stiffness;
      logic [30:0]        damping;
      bit                 typed;
      logic signed [31:0] typed_torque;
      bit                 typed_clipped;
   } joint_beat_type;

   typedef struct {
      logic [2:0]         joint;
      logic signed [31:0] torque;
      bit                 clipped;
   } torque_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_kind = '0;
   logic [2:0]         req_joint = '0;
   logic signed [31:0] req_position = '0;
   logic signed [31:0] req_velocity = '0;
   logic signed [31:0] req_coriolis_torque = '0;
   logic signed [31:0] req_velocity_command = '0;
   logic signed [31:0] req_previous_torque = '0;
   logic [23:0]        req_time_step = '0;
   logic [30:0]        req_stiffness = '0;
   logic [30:0]        req_damping = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_joint_out;
   logic signed [31:0] rsp_torque_command;
   logic               rsp_clipped;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [3:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   joint_impedance_torque_rate_limit_unit dut (.*);

   // Free-running 50 MHz clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Our own copy of the controller state and its registers.
   longint desired_pos [jitrl_pkg::JOINTS];
   longint filt_vel [jitrl_pkg::JOINTS];
   longint stiff_gain [jitrl_pkg::JOINTS];
   longint damp_gain [jitrl_pkg::JOINTS];
   longint cor_scale;
   longint max_step;
   longint flt_weight;

   torque_result_type torque_queue[$];
   int mismatches = 0;
   int cycle_count = 0;
   joint_beat_type stim_rows[$];

   // Both sides stall about a third of the time, except in a quiet window
   // at the start of each repeating period of the cycle count, where they run flat out.
   function automatic bit take_break();
      if ((cycle_count % 20000) < 3000) return 1'b0;
      return $urandom_range(99) < 32;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_ready <= !take_break();
   end

   function automatic longint round_q(input longint x, input int s);
      return (x + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp32(input longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   // Applies one beat to the state; returns 1 with the torque when the beat
   // is a control sample for a joint that exists.
   function automatic bit predict_torque(input joint_beat_type b,
                                         output torque_result_type r);
      longint w, tau, delta, cmd;
      int j;
      j = int'(b.joint);
      r = '{default: '0};
      if (j >= jitrl_pkg::JOINTS) return 1'b0;
      if (b.kind == jitrl_pkg::KIND_LOAD) begin
         stiff_gain[j] = longint'(b.stiffness);
         damp_gain[j] = longint'(b.damping);
         return 1'b0;
      end
      if (b.kind == jitrl_pkg::KIND_START) begin
         desired_pos[j] = longint'(b.position);
         return 1'b0;
      end
      if (b.kind != jitrl_pkg::KIND_CONTROL) return 1'b0;
      // A weight above one behaves as exactly one.
      w = (flt_weight > 64'sd65536) ? 64'sd65536 : flt_weight;
      filt_vel[j] = clamp32(round_q((64'sd65536 - w) * filt_vel[j]
                                    + w * longint'(b.velocity), 16));
      desired_pos[j] = clamp32(desired_pos[j]
         + round_q(longint'(b.velocity_command) * longint'(b.time_step), 24));
      tau = round_q(cor_scale * longint'(b.coriolis_torque), 16)
          + round_q(stiff_gain[j] * (desired_pos[j] - longint'(b.position)), 16)
          + round_q(damp_gain[j] * (longint'(b.velocity_command) - filt_vel[j]), 16);
      delta = tau - longint'(b.previous_torque);
      if (delta > max_step) delta = max_step;
      if (delta < -max_step) delta = -max_step;
      cmd = clamp32(longint'(b.previous_torque) + delta);
      r.joint = b.joint;
      r.torque = cmd[31:0];
      r.clipped = (cmd != tau);
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // Result side: each rsp_ beat is held against the oldest expectation.
   always @(posedge clock) begin
      torque_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (torque_queue.size() == 0) begin
            report_mismatch("unexpected result", longint'(rsp_torque_command), 64'sd0);
         end else begin
            want = torque_queue.pop_front();
            if (rsp_joint_out !== want.joint)
               report_mismatch("joint_out", longint'(rsp_joint_out), longint'(want.joint));
            if (rsp_torque_command !== want.torque)
               report_mismatch("torque_command", longint'(rsp_torque_command),
                               longint'(want.torque));
            if (rsp_clipped !== want.clipped)
               report_mismatch("clipped", longint'(rsp_clipped), longint'(want.clipped));
         end
      end
   end

   // Two-phase register write; the register takes the value at the access edge.
   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         jitrl_pkg::CSR_CORIOLIS: cor_scale = longint'(signed'(value));
         jitrl_pkg::CSR_MAXSTEP:  max_step = longint'(value[30:0]);
         jitrl_pkg::CSR_WEIGHT:   flt_weight = longint'(value[16:0]);
         default: ;
      endcase
   endtask

   task automatic configure(input logic [31:0] scale, input logic [31:0] step,
                            input logic [31:0] weight);
      write_csr(jitrl_pkg::CSR_CORIOLIS, scale);
      write_csr(jitrl_pkg::CSR_MAXSTEP, step);
      write_csr(jitrl_pkg::CSR_WEIGHT, weight);
   endtask

   // Drives one beat, holding it until accepted, then predicts its result.
   task automatic send_beat(input joint_beat_type b);
      torque_result_type r;
      while (take_break()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= b.kind;
      req_joint <= b.joint;
      req_position <= b.position;
      req_velocity <= b.velocity;
      req_coriolis_torque <= b.coriolis_torque;
      req_velocity_command <= b.velocity_command;
      req_previous_torque <= b.previous_torque;
      req_time_step <= b.time_step;
      req_stiffness <= b.stiffness;
      req_damping <= b.damping;
      do @(posedge clock); while (!req_ready);
      if (predict_torque(b, r)) begin
         if (b.typed) begin
            r.torque = b.typed_torque;
            r.clipped = b.typed_clipped;
         end
         torque_queue = {torque_queue, r};
      end
   endtask

   // Waits until every result is back, plus slack for dropped or queued beats.
   task automatic drain();
      req_valid <= 1'b0;
      while (torque_queue.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // Values that mix tiny, moderate, extreme and fully random patterns.
   function automatic logic [31:0] pick32();
      case ($urandom_range(7))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
         2, 3: return 32'(signed'($urandom_range(4000, 0)) - 2000);
         default: return 32'(signed'($urandom_range(600000, 0)) - 300000);
      endcase
   endfunction

   function automatic logic [30:0] pick_gain();
      case ($urandom_range(5))
         0: return 31'($urandom);
         1: return 31'h7fffffff;
         default: return 31'($urandom_range(400000));
      endcase
   endfunction

   function automatic joint_beat_type random_beat(input logic [1:0] kind,
                                                  input logic [2:0] joint);
      joint_beat_type b;
      b.kind = kind;
      b.joint = joint;
      b.position = pick32();
      b.velocity = pick32();
      b.coriolis_torque = pick32();
      b.velocity_command = pick32();
      b.previous_torque = pick32();
      b.time_step = $urandom_range(2) == 0 ? 24'($urandom) : 24'($urandom_range(20000));
      b.stiffness = pick_gain();
      b.damping = pick_gain();
      b.typed = 1'b0;
      b.typed_torque = '0;
      b.typed_clipped = 1'b0;
      return b;
   endfunction

   function automatic joint_beat_type row(input logic [1:0] kind, input logic [2:0] joint,
         input logic [31:0] pos, input logic [31:0] vel, input logic [31:0] cor,
         input logic [31:0] vcmd, input logic [31:0] prev, input logic [23:0] ts,
         input logic [30:0] k, input logic [30:0] d);
      joint_beat_type b;
      b = '{kind, joint, pos, vel, cor, vcmd, prev, ts, k, d, 1'b0, 32'sd0, 1'b0};
      return b;
   endfunction

   function automatic void add_row(input joint_beat_type b);
      stim_rows = {stim_rows, b};
   endfunction

   // Directed rows: reset state, extremes of every field, every kind, and
   // the beats that must be dropped.
   function automatic void build_rows();
      joint_beat_type b;
      // Control before any load or start: everything is zero.
      b = row(jitrl_pkg::KIND_CONTROL, 3'd0, 0, 0, 0, 0, 0, 24'd0, 31'd0, 31'd0);
      b.typed = 1'b1;
      add_row(b);
      // Largest Coriolis torque from rest is held to one step of 1.0.
      b = row(jitrl_pkg::KIND_CONTROL, 3'd1, 0, 0, 32'h7fffffff, 0, 0, 24'd0, 31'd0, 31'd0);
      b.typed = 1'b1; b.typed_torque = 32'sd65536; b.typed_clipped = 1'b1;
      add_row(b);
      // Most negative Coriolis torque, step limited downward.
      b = row(jitrl_pkg::KIND_CONTROL, 3'd2, 0, 0, 32'h80000000, 0, 0, 24'd0, 31'd0, 31'd0);
      b.typed = 1'b1; b.typed_torque = -32'sd65536; b.typed_clipped = 1'b1;
      add_row(b);
      // A small torque inside the step passes unchanged.
      b = row(jitrl_pkg::KIND_CONTROL, 3'd3, 0, 0, 32'd1000, 0, 0, 24'd0, 31'd0, 31'd0);
      b.typed = 1'b1; b.typed_torque = 32'sd1000;
      add_row(b);
      // Load, start and then control on the same joint.
      add_row(row(jitrl_pkg::KIND_LOAD, 3'd4, 0, 0, 0, 0, 0, 24'd0,
                  31'h7fffffff, 31'h7fffffff));
      add_row(row(jitrl_pkg::KIND_START, 3'd4, 32'h7fffffff, 0, 0, 0, 0, 24'd0,
                  31'd0, 31'd0));
      add_row(row(jitrl_pkg::KIND_CONTROL, 3'd4, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                  32'h7fffffff, 32'h7fffffff, 24'hffffff, 31'd0, 31'd0));
      add_row(row(jitrl_pkg::KIND_CONTROL, 3'd4, 32'h7fffffff, 32'h80000000, 32'h80000000,
                  32'h80000000, 32'h80000000, 24'hffffff, 31'd0, 31'd0));
      add_row(row(jitrl_pkg::KIND_LOAD, 3'd6, 0, 0, 0, 0, 0, 24'd0, 31'd65536, 31'd32768));
      add_row(row(jitrl_pkg::KIND_START, 3'd6, 32'd65536, 0, 0, 0, 0, 24'd0, 31'd0, 31'd0));
      add_row(row(jitrl_pkg::KIND_CONTROL, 3'd6, 0, 32'd131072, 0, 32'd65536, 32'd20000,
                  24'd16777, 31'd0, 31'd0));
      add_row(row(jitrl_pkg::KIND_CONTROL, 3'd6, 32'hffffffff, 32'hffff0000, 32'hfff00000,
                  32'hffffffff, 32'h7fffffff, 24'd1, 31'd0, 31'd0));
      // A joint that does not exist and the unused kind leave no trace.
      add_row(row(jitrl_pkg::KIND_LOAD, 3'd7, 0, 0, 0, 0, 0, 24'd0,
                  31'h7fffffff, 31'h7fffffff));
      add_row(row(jitrl_pkg::KIND_CONTROL, 3'd7, 0, 0, 32'h7fffffff, 0, 0, 24'd0,
                  31'd0, 31'd0));
      add_row(row(jitrl_pkg::KIND_UNUSED, 3'd5, 0, 0, 32'h7fffffff, 0, 0, 24'd0,
                  31'd0, 31'd0));
      add_row(row(jitrl_pkg::KIND_CONTROL, 3'd5, 0, 32'h55555555, 32'haaaaaaaa, 0, 0,
                  24'haaaaaa, 31'd0, 31'd0));
   endfunction

   // A phase of random traffic: mostly load/start/control sequences on one
   // joint with random content, the rest single random beats of any kind.
   task automatic random_phase(input int count);
      int sent;
      int n;
      logic [2:0] j;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(9) < 7) begin
            j = 3'($urandom_range(jitrl_pkg::JOINTS - 1));
            if ($urandom_range(2) != 0) begin
               send_beat(random_beat(jitrl_pkg::KIND_LOAD, j));
               sent++;
            end
            if ($urandom_range(1)) begin
               send_beat(random_beat(jitrl_pkg::KIND_START, j));
               sent++;
            end
            n = $urandom_range(6, 1);
            repeat (n) begin
               send_beat(random_beat(jitrl_pkg::KIND_CONTROL, j));
               sent++;
            end
         end else begin
            send_beat(random_beat(2'($urandom), 3'($urandom)));
            sent++;
         end
      end
   endtask

   // Main sequence: reset, directed rows, then random phases under a range
   // of register settings, extremes included.
   initial begin
      for (int i = 0; i < jitrl_pkg::JOINTS; i++) begin
         desired_pos[i] = 0;
         filt_vel[i] = 0;
         stiff_gain[i] = 0;
         damp_gain[i] = 0;
      end
      cor_scale = 65536;
      max_step = 65536;
      flt_weight = 64881;
      build_rows();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (stim_rows[i]) send_beat(stim_rows[i]);
      drain();
      random_phase(200);
      drain();
      configure(32'h80000000, 32'h0, 32'd0);
      random_phase(190);
      drain();
      configure(32'h7fffffff, 32'h7fffffff, 32'd65536);
      random_phase(190);
      drain();
      configure(32'h0, 32'h3fffffff, 32'h1ffff);
      random_phase(190);
      drain();
      for (int p = 0; p < 4; p++) begin
         configure(pick32(), $urandom_range(1) ? 32'($urandom_range(2000000)) : $urandom,
                   $urandom_range(1) ? 32'($urandom_range(65536)) : 32'($urandom));
         random_phase(190);
         drain();
      end
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #(20 * 1000000);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
